// ===== rtl/sefp_pkg.sv =====
// Package for the serial event frame parser: parser phase type, register
// indexes and register reset values. Depends on nothing.
package sefp_pkg;

   localparam int unsigned CsrIndexWidth = 2;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_HEADER_FIRST  = 2'd0;
   localparam csr_index_type CSR_HEADER_SECOND = 2'd1;
   localparam csr_index_type CSR_MAX_WORDS     = 2'd2;

   localparam logic [7:0] HEADER_FIRST_RESET  = 8'd90;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'd165;
   localparam logic [7:0] MAX_WORDS_RESET     = 8'd255;

   // Bytes in a frame ahead of the data words, after the length byte.
   localparam logic [9:0] LENGTH_OVERHEAD = 10'd4;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_HDR2    = 4'd1,
      PH_LEN     = 4'd2,
      PH_CMD     = 4'd3,
      PH_ADDR_HI = 4'd4,
      PH_ADDR_LO = 4'd5,
      PH_COUNT   = 4'd6,
      PH_WORD_HI = 4'd7,
      PH_WORD_LO = 4'd8
   } phase_type;

endpackage

// ===== rtl/serial_event_frame_parser.sv =====
// Serial event frame parser: top level holding the parser state machine,
// the register file and the result register. Depends on sefp_pkg.
//
// Usage: received bytes enter on the req_ channel, one byte per item. A
// frame is two header bytes, a length byte, a command byte, a big-endian
// address, a word count and that many big-endian 16-bit words. Each word
// below max_words gives a data item on the rsp_ channel; the last word, or
// a zero count, gives a frame-end item carrying the length check instead.
// The csr_ channel writes header_first, header_second and max_words; it is
// always ready, and the user must write it only while the parser is idle,
// as the block does not enforce this. A byte's result item appears in the
// cycle after it is accepted. One byte is taken in every cycle that
// req_stall is low, as its state update and result are combinational and
// the result register holds the item. When the receiver stalls a waiting
// item, req_stall is raised until the item is taken, while the state
// machine holds. A synchronous reset returns the parser to hunting for the
// first header byte, clears rsp_valid and restores register reset values.
module serial_event_frame_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_command,
   output logic [15:0]            rsp_address,
   output logic [7:0]             rsp_word_index,
   output logic [15:0]            rsp_word_value,
   output logic [7:0]             rsp_word_count,
   output logic                   rsp_frame_ok,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sefp_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_data
);
   import sefp_pkg::*;

   logic [7:0]  header_first_ff, header_second_ff, max_words_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] address_ff, address_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  high_ff, high_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_command_ff;
   logic [15:0] rsp_address_ff;
   logic [7:0]  rsp_word_index_ff, rsp_word_index_in;
   logic [15:0] rsp_word_value_ff, rsp_word_value_in;
   logic [7:0]  rsp_word_count_ff;
   logic        rsp_frame_ok_ff, rsp_frame_ok_in;

   logic        req_accept, rsp_take, emit;
   logic [7:0]  index_next;
   logic [15:0] word;
   logic [7:0]  check_count;
   logic        length_match;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RESET;
         header_second_ff <= HEADER_SECOND_RESET;
         max_words_ff     <= MAX_WORDS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  header_first_ff  <= csr_data;
            CSR_HEADER_SECOND: header_second_ff <= csr_data;
            CSR_MAX_WORDS:     max_words_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign index_next = index_ff + 8'd1;
   assign word       = {high_ff, req_rx_byte};

   // Next phase.
   always_comb begin
      unique case (phase_ff)
         PH_HDR2:    phase_in = (req_rx_byte == header_second_ff) ? PH_LEN : PH_HUNT;
         PH_LEN:     phase_in = PH_CMD;
         PH_CMD:     phase_in = PH_ADDR_HI;
         PH_ADDR_HI: phase_in = PH_ADDR_LO;
         PH_ADDR_LO: phase_in = PH_COUNT;
         PH_COUNT:   phase_in = (req_rx_byte == 8'd0) ? PH_HUNT : PH_WORD_HI;
         PH_WORD_HI: phase_in = PH_WORD_LO;
         PH_WORD_LO: phase_in = (index_next == count_ff) ? PH_HUNT : PH_WORD_HI;
         default:    phase_in = (req_rx_byte == header_first_ff) ? PH_HDR2 : PH_HUNT;
      endcase
   end

   // On the count byte the length check uses the count that is arriving.
   assign check_count  = (phase_ff == PH_COUNT) ? req_rx_byte : count_ff;
   assign length_match = ({2'b00, length_ff} ==
                          (LENGTH_OVERHEAD + {1'b0, check_count, 1'b0}));

   // Held fields and the result for this byte.
   always_comb begin
      length_in         = length_ff;
      command_in        = command_ff;
      address_in        = address_ff;
      count_in          = count_ff;
      index_in          = index_ff;
      high_in           = high_ff;
      emit              = 1'b0;
      rsp_kind_in       = 1'b0;
      rsp_word_index_in = index_ff;
      rsp_word_value_in = word;
      rsp_frame_ok_in   = 1'b0;
      unique case (phase_ff)
         PH_LEN:     length_in  = req_rx_byte;
         PH_CMD:     command_in = req_rx_byte;
         PH_ADDR_HI: address_in = {req_rx_byte, 8'd0};
         PH_ADDR_LO: address_in = {address_ff[15:8], req_rx_byte};
         PH_COUNT: begin
            count_in = req_rx_byte;
            index_in = 8'd0;
            if (req_rx_byte == 8'd0) begin
               emit              = 1'b1;
               rsp_kind_in       = 1'b1;
               rsp_word_index_in = 8'd0;
               rsp_word_value_in = 16'd0;
               rsp_frame_ok_in   = length_match;
            end
         end
         PH_WORD_HI: high_in = req_rx_byte;
         PH_WORD_LO: begin
            index_in = index_next;
            if (index_next == count_ff) begin
               emit            = 1'b1;
               rsp_kind_in     = 1'b1;
               rsp_frame_ok_in = length_match;
            end else if (index_ff < max_words_ff) begin
               emit = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      if (req_accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         length_ff    <= 8'd0;
         command_ff   <= 8'd0;
         address_ff   <= 16'd0;
         count_ff     <= 8'd0;
         index_ff     <= 8'd0;
         high_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff   <= phase_in;
            length_ff  <= length_in;
            command_ff <= command_in;
            address_ff <= address_in;
            count_ff   <= count_in;
            index_ff   <= index_in;
            high_ff    <= high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_kind_ff       <= rsp_kind_in;
         rsp_command_ff    <= command_in;
         rsp_address_ff    <= address_in;
         rsp_word_index_ff <= rsp_word_index_in;
         rsp_word_value_ff <= rsp_word_value_in;
         rsp_word_count_ff <= count_in;
         rsp_frame_ok_ff   <= rsp_frame_ok_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_command    = rsp_command_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_word_index = rsp_word_index_ff;
   assign rsp_word_value = rsp_word_value_ff;
   assign rsp_word_count = rsp_word_count_ff;
   assign rsp_frame_ok   = rsp_frame_ok_ff;

   a_data_no_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_kind_ff |-> !rsp_frame_ok_ff)
      else $error("data item carries a frame check");

   a_data_below_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_kind_ff |-> rsp_word_index_ff < max_words_ff)
      else $error("data item at or past the word limit");

   a_zero_count_end: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_COUNT && req_rx_byte == 8'd0
      |=> phase_ff == PH_HUNT && rsp_valid_ff && rsp_kind_ff)
      else $error("zero count did not end the frame");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for serial_event_frame_parser: drives byte streams of frames and noise,
// predicts every result item from its own copy of the parser state and compares field by field.
// Depends on sefp_pkg and serial_event_frame_parser.
module tb;
   import sefp_pkg::*;

   localparam logic KIND_WORD      = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   typedef struct {
      logic        kind;
      logic [7:0]  command;
      logic [15:0] address;
      logic [7:0]  word_index;
      logic [15:0] word_value;
      logic [7:0]  word_count;
      logic        frame_ok;
   } frame_result_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_pattern_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [7:0]    req_rx_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_kind;
   logic [7:0]    rsp_command;
   logic [15:0]   rsp_address;
   logic [7:0]    rsp_word_index;
   logic [15:0]   rsp_word_value;
   logic [7:0]    rsp_word_count;
   logic          rsp_frame_ok;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_HEADER_FIRST;
   logic [7:0]    csr_data = 8'h00;

   logic [7:0]    rx_stream [$];
   frame_result_type expected_results [$];
   int unsigned   failures = 0;

   logic [7:0]    cfg_header_first = HEADER_FIRST_RESET;
   logic [7:0]    cfg_header_second = HEADER_SECOND_RESET;
   logic [7:0]    cfg_max_words = MAX_WORDS_RESET;

   phase_type     parse_phase = PH_HUNT;
   logic [7:0]    length_hold = 8'h00;
   logic [7:0]    command_hold = 8'h00;
   logic [15:0]   address_hold = 16'h0000;
   logic [7:0]    count_hold = 8'h00;
   logic [7:0]    index_count = 8'h00;
   logic [7:0]    high_hold = 8'h00;

   int unsigned   burst_left = 1;
   int unsigned   gap_left = 0;
   int unsigned   hold_left = 0;
   bit            long_hold_done = 1'b0;
   int unsigned   pattern_left = 0;
   stall_pattern_type stall_pattern = STALL_NONE;
   frame_result_type received;
   frame_result_type wanted;

   serial_event_frame_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_command    (rsp_command),
      .rsp_address    (rsp_address),
      .rsp_word_index (rsp_word_index),
      .rsp_word_value (rsp_word_value),
      .rsp_word_count (rsp_word_count),
      .rsp_frame_ok   (rsp_frame_ok),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic length_matches();
      return {2'b00, length_hold} == LENGTH_OVERHEAD + {1'b0, count_hold, 1'b0};
   endfunction

   function automatic frame_result_type make_result(input logic kind, input logic [7:0] index,
                                                    input logic [15:0] value, input logic ok);
      frame_result_type r;
      r.kind       = kind;
      r.command    = command_hold;
      r.address    = address_hold;
      r.word_index = index;
      r.word_value = value;
      r.word_count = count_hold;
      r.frame_ok   = ok;
      return r;
   endfunction

   task automatic parse_byte(input logic [7:0] b);
      logic [15:0] word;
      logic [7:0]  index;
      case (parse_phase)
         PH_HDR2: begin
            if (b == cfg_header_second) parse_phase = PH_LEN;
            else parse_phase = PH_HUNT;
         end
         PH_LEN: begin
            length_hold = b;
            parse_phase = PH_CMD;
         end
         PH_CMD: begin
            command_hold = b;
            parse_phase = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            address_hold = {b, 8'h00};
            parse_phase = PH_ADDR_LO;
         end
         PH_ADDR_LO: begin
            address_hold[7:0] = b;
            parse_phase = PH_COUNT;
         end
         PH_COUNT: begin
            count_hold = b;
            index_count = 8'h00;
            if (b == 8'h00) begin
               parse_phase = PH_HUNT;
               expected_results.push_back(make_result(KIND_FRAME_END, 8'h00, 16'h0000,
                                                      length_matches()));
            end else begin
               parse_phase = PH_WORD_HI;
            end
         end
         PH_WORD_HI: begin
            high_hold = b;
            parse_phase = PH_WORD_LO;
         end
         PH_WORD_LO: begin
            word = {high_hold, b};
            index = index_count;
            index_count = index_count + 8'd1;
            if (index_count == count_hold) begin
               parse_phase = PH_HUNT;
               expected_results.push_back(make_result(KIND_FRAME_END, index, word,
                                                      length_matches()));
            end else begin
               parse_phase = PH_WORD_HI;
               if (index < cfg_max_words)
                  expected_results.push_back(make_result(KIND_WORD, index, word, 1'b0));
            end
         end
         default: begin
            if (b == cfg_header_first) parse_phase = PH_HDR2;
            else parse_phase = PH_HUNT;
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want_value,
                              input int unsigned got_value);
      if (want_value != got_value) begin
         $error("%s: expected %0h, got %0h", name, want_value, got_value);
         failures++;
      end
   endtask

   // Byte sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_rx_byte);
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
               burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = $urandom_range(50, 150);
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 20);
                     gap_left = $urandom_range(1, 6);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: one long hold-off while bytes are queued, otherwise changing patterns.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && rx_stream.size() > 64) begin
         long_hold_done = 1'b1;
         hold_left = 250;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 200);
         end else begin
            pattern_left--;
         end
         case (stall_pattern)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         received.kind       = rsp_kind;
         received.command    = rsp_command;
         received.address    = rsp_address;
         received.word_index = rsp_word_index;
         received.word_value = rsp_word_value;
         received.word_count = rsp_word_count;
         received.frame_ok   = rsp_frame_ok;
         if (expected_results.size() == 0) begin
            $error("result item with none expected: kind %0h index %0h value %0h",
                   received.kind, received.word_index, received.word_value);
            failures++;
         end else begin
            wanted = expected_results.pop_front();
            check_field("kind", wanted.kind, received.kind);
            check_field("command", wanted.command, received.command);
            check_field("address", wanted.address, received.address);
            check_field("word_index", wanted.word_index, received.word_index);
            check_field("word_value", wanted.word_value, received.word_value);
            check_field("word_count", wanted.word_count, received.word_count);
            check_field("frame_ok", wanted.frame_ok, received.frame_ok);
         end
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (rx_stream.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] first, input logic [7:0] second,
                                input logic [7:0] limit);
      csr_index_type reg_order [3] = '{CSR_HEADER_FIRST, CSR_HEADER_SECOND, CSR_MAX_WORDS};
      logic [7:0]    reg_value [3];
      reg_value = '{first, second, limit};
      @(posedge clock);
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= reg_order[i];
         csr_data <= reg_value[i];
         do @(posedge clock);
         while (!csr_ready);
         case (reg_order[i])
            CSR_HEADER_FIRST:  cfg_header_first = reg_value[i];
            CSR_HEADER_SECOND: cfg_header_second = reg_value[i];
            default:           cfg_max_words = reg_value[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic queue_frame(input int unsigned count, input bit length_good);
      logic [7:0] length;
      if (length_good && count <= 125) length = 8'(4 + 2 * count);
      else length = 8'($urandom_range(0, 255));
      rx_stream.push_back(cfg_header_first);
      rx_stream.push_back(cfg_header_second);
      rx_stream.push_back(length);
      rx_stream.push_back(8'($urandom_range(0, 255)));
      rx_stream.push_back(8'($urandom_range(0, 255)));
      rx_stream.push_back(8'($urandom_range(0, 255)));
      rx_stream.push_back(8'(count));
      for (int i = 0; i < 2 * count; i++) rx_stream.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                            input logic [7:0] limit, input int unsigned budget,
                            input bit long_frame);
      int unsigned start;
      int unsigned pick;
      int unsigned count;
      logic [7:0]  wrong;
      apply_setting(first, second, limit);
      start = rx_stream.size();
      if (long_frame) queue_frame($urandom_range(126, 255), 1'b0);
      while (rx_stream.size() - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            count = $urandom_range(0, 99);
            if (count < 60) count = $urandom_range(0, 4);
            else if (count < 90) count = $urandom_range(0, 12);
            else count = $urandom_range(0, 40);
            queue_frame(count, $urandom_range(0, 1));
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) rx_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            // Either a broken header or a truncated frame cut off at a random point.
            if (pick < 95) begin
               do wrong = 8'($urandom_range(0, 255));
               while (wrong == cfg_header_second);
               rx_stream.push_back(cfg_header_first);
               if ($urandom_range(0, 1) == 1) rx_stream.push_back(cfg_header_first);
               else rx_stream.push_back(wrong);
            end else begin
               rx_stream.push_back(cfg_header_first);
               rx_stream.push_back(cfg_header_second);
               repeat ($urandom_range(1, 6)) rx_stream.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Noise while hunting, a wrong second header byte that is not rechecked, a zero-count
      // frame with a good length, and a frame with extreme fields ending on its last word.
      rx_stream = '{8'h00, 8'hFF,
                    HEADER_FIRST_RESET, HEADER_FIRST_RESET, HEADER_SECOND_RESET,
                    HEADER_FIRST_RESET, HEADER_SECOND_RESET, 8'h04, 8'h00, 8'h00, 8'h00,
                    8'h00,
                    HEADER_FIRST_RESET, HEADER_SECOND_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00};
      drain();
      run_phase(8'h00, 8'hFF, 8'h00, 150, 1'b0);
      run_phase(8'hFF, 8'h00, 8'hFF, 150, 1'b1);
      run_phase(8'hFF, 8'hFF, 8'h01, 150, 1'b0);
      run_phase(8'h00, 8'h00, 8'h03, 150, 1'b0);
      repeat (3) run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(2, 10)), 150, 1'b0);
      repeat (8) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
